[sv/tcas_pkg.sv]
// Shared types and constants for the traffic cellular automaton step block.
// Used by tcas_cell and traffic_cellular_automaton_step; no dependencies.
`default_nettype none

package tcas_pkg;

  localparam int unsigned NUM_CELLS_DEF   = 128;
  localparam int unsigned SPEED_LIMIT_DEF = 3;

  localparam int unsigned SPD_W   = 2;   // speed and top speed field width
  localparam int unsigned SPD_MAX = 3;   // largest speed a 2-bit field holds
  localparam int unsigned IDX_W   = 7;   // cell_index width
  localparam int unsigned CNT_OUT_W = 8; // vehicle_total width
  localparam int unsigned EXIT_W  = 2;   // exited_count width

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic             inject;
    logic [SPD_W-1:0] new_top_speed;
    logic [SPD_W-1:0] new_speed;
    logic [IDX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic                 cell_occupied;
    logic [SPD_W-1:0]     cell_speed;
    logic [SPD_W-1:0]     cell_top_speed;
    logic [EXIT_W-1:0]    exited_count;
    logic [CNT_OUT_W-1:0] vehicle_total;
  } res_t;

  // contents of one road cell
  typedef struct packed {
    logic             occ;
    logic [SPD_W-1:0] spd;
    logic [SPD_W-1:0] top;
  } cell_t;

  // a vehicle leaving a cell: new speed doubles as the hop distance
  typedef struct packed {
    logic             vld;
    logic [SPD_W-1:0] spd;
    logic [SPD_W-1:0] top;
  } move_t;

endpackage

`default_nettype wire

[sv/traffic_cellular_automaton_step.sv]
// Top level of the traffic cellular automaton step block: a row of road cells.
// Depends on tcas_pkg and tcas_cell.
`default_nettype none

// A tick word moves the whole road at once: every cell looks at the
// next three cells for its gap and at the three cells behind for an arriving
// vehicle, and all cells load at the accepting edge. Its result strobes on
// done_o in the following cycle and busy stays low, so ticks may come back
// to back. A read word goes through a two-stage registered select over the
// cells (groups of 16, then the groups): busy is high while the group hits
// wait in grp_q, and the result strobes once res_q is loaded from them.
// Results cannot be held off; each is on res_o from the cycle done_o is
// high until the next result. No clearing pass is needed after reset.

module traffic_cellular_automaton_step #(
  parameter int unsigned NUM_CELLS   = tcas_pkg::NUM_CELLS_DEF,
  parameter int unsigned SPEED_LIMIT = tcas_pkg::SPEED_LIMIT_DEF
) (
  input  wire  logic           clk_i,
  input  wire  logic           rst_ni,
  input  wire  logic           start,
  input  wire  tcas_pkg::req_t req_i,
  output logic                 busy,
  output logic                 done_o,
  output tcas_pkg::res_t       res_o
);

  localparam int unsigned GRP   = 16;
  localparam int unsigned NGRP  = (NUM_CELLS + GRP - 1) / GRP;
  localparam int unsigned CNTW  = $clog2(NUM_CELLS + 1);
  localparam logic [2:0]  SL3   = 3'(SPEED_LIMIT);
  localparam int unsigned SMAX  = tcas_pkg::SPD_MAX;

  tcas_pkg::cell_t st   [NUM_CELLS];
  tcas_pkg::cell_t rd   [NUM_CELLS];
  tcas_pkg::move_t mv   [NUM_CELLS];
  logic            ex   [NUM_CELLS];

  tcas_pkg::cell_t grp_q [NGRP];
  tcas_pkg::cell_t grp_d [NGRP];
  tcas_pkg::cell_t inj;
  tcas_pkg::cell_t rd_sel;
  tcas_pkg::res_t  res_q, res_d;

  logic            rd_pend_q, rd_pend_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            tick_acc, read_acc, inj_en, inj_new;
  logic [tcas_pkg::EXIT_W-1:0] exits;
  logic [tcas_pkg::SPD_W-1:0]  top_c;

  function automatic logic [tcas_pkg::CNT_OUT_W-1:0] sat_total(input logic [CNTW-1:0] c);
    sat_total = (16'(c) > 16'd255) ? 8'hFF : tcas_pkg::CNT_OUT_W'(c);
  endfunction

  assign busy     = rd_pend_q;
  assign tick_acc = start && !busy && (req_i.req_type == tcas_pkg::REQ_TICK);
  assign read_acc = start && !busy && (req_i.req_type == tcas_pkg::REQ_READ);
  assign inj_en   = tick_acc && req_i.inject;

  // injected vehicle: top speed into 1..SPEED_LIMIT, speed capped at top
  always_comb begin
    top_c = req_i.new_top_speed;
    if (top_c == '0) begin
      top_c = tcas_pkg::SPD_W'(1);
    end else if ({1'b0, top_c} > SL3) begin
      top_c = tcas_pkg::SPD_W'(SL3);
    end
    inj.occ = 1'b1;
    inj.top = top_c;
    inj.spd = (req_i.new_speed > top_c) ? top_c : req_i.new_speed;
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic [SMAX-1:0]                     ahead;
    tcas_pkg::move_t [SMAX-1:0]          arrive;

    for (genvar a = 1; a <= SMAX; a++) begin : g_nb
      if (k + a < NUM_CELLS) begin : g_in
        assign ahead[a-1] = st[k+a].occ;
      end else begin : g_off
        assign ahead[a-1] = 1'b1;
      end
      if (k >= a) begin : g_up
        assign arrive[a-1] = mv[k-a];
      end else begin : g_none
        assign arrive[a-1] = '0;
      end
    end

    if (k == 0) begin : g_head
      tcas_cell #(.NUM_CELLS(NUM_CELLS), .INDEX(k)) u_cell (
        .clk_i, .rst_ni,
        .tick_i   (tick_acc),
        .inj_en_i (inj_en),
        .inj_i    (inj),
        .ahead_i  (ahead),
        .arrive_i (arrive),
        .rd_idx_i (req_i.cell_index),
        .state_o  (st[k]),
        .move_o   (mv[k]),
        .exit_o   (ex[k]),
        .rd_o     (rd[k])
      );
    end else begin : g_body
      tcas_cell #(.NUM_CELLS(NUM_CELLS), .INDEX(k)) u_cell (
        .clk_i, .rst_ni,
        .tick_i   (tick_acc),
        .inj_en_i (1'b0),
        .inj_i    ('0),
        .ahead_i  (ahead),
        .arrive_i (arrive),
        .rd_idx_i (req_i.cell_index),
        .state_o  (st[k]),
        .move_o   (mv[k]),
        .exit_o   (ex[k]),
        .rd_o     (rd[k])
      );
    end
  end

  // only the last SMAX cells can reach the road end
  always_comb begin
    exits = '0;
    for (int k = NUM_CELLS - SMAX; k < NUM_CELLS; k++) begin
      exits = exits + tcas_pkg::EXIT_W'(ex[k]);
    end
  end

  // replacing a vehicle at cell 0 does not add one
  assign inj_new = inj_en && !st[0].occ;
  // no two vehicles ever land on one cell, so the count tracks adds and exits
  assign cnt_d   = tick_acc ? (cnt_q + CNTW'(inj_new) - CNTW'(exits)) : cnt_q;

  // read select, first stage: one hit per group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int c = 0; c < GRP; c++) begin
        if (g * GRP + c < NUM_CELLS) begin
          grp_d[g] = grp_d[g] | rd[g * GRP + c];
        end
      end
    end
  end

  always_comb begin
    rd_sel = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_sel = rd_sel | grp_q[g];
    end
  end

  always_comb begin
    done_d    = 1'b0;
    rd_pend_d = read_acc;
    res_d     = res_q;
    if (tick_acc) begin
      done_d               = 1'b1;
      res_d.cell_occupied  = 1'b0;
      res_d.cell_speed     = '0;
      res_d.cell_top_speed = '0;
      res_d.exited_count   = exits;
      res_d.vehicle_total  = sat_total(cnt_d);
    end else if (rd_pend_q) begin
      done_d               = 1'b1;
      res_d.cell_occupied  = rd_sel.occ;
      res_d.cell_speed     = rd_sel.spd;
      res_d.cell_top_speed = rd_sel.top;
      res_d.exited_count   = '0;
      res_d.vehicle_total  = sat_total(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      res_q <= res_d;
    end
    if (read_acc) begin
      grp_q <= grp_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[sv/tcas_cell.sv]
// One road cell: holds its vehicle, works out its move and picks its arrival.
// Depends on tcas_pkg.
`default_nettype none

module tcas_cell #(
  parameter int unsigned NUM_CELLS = tcas_pkg::NUM_CELLS_DEF,
  parameter int unsigned INDEX     = 0
) (
  input  wire  logic                                clk_i,
  input  wire  logic                                rst_ni,
  input  wire  logic                                tick_i,
  input  wire  logic                                inj_en_i,
  input  wire  tcas_pkg::cell_t                     inj_i,
  // bit k-1: cell INDEX+k is occupied or off the road
  input  wire  logic [tcas_pkg::SPD_MAX-1:0]        ahead_i,
  // entry k-1: move leaving cell INDEX-k
  input  wire  tcas_pkg::move_t [tcas_pkg::SPD_MAX-1:0] arrive_i,
  input  wire  logic [tcas_pkg::IDX_W-1:0]          rd_idx_i,
  output tcas_pkg::cell_t                           state_o,
  output tcas_pkg::move_t                           move_o,
  output logic                                      exit_o,
  output tcas_pkg::cell_t                           rd_o
);

  localparam int unsigned PW = $clog2(NUM_CELLS + tcas_pkg::SPD_MAX + 1) + 1;
  localparam int unsigned CW = ($clog2(NUM_CELLS) > tcas_pkg::IDX_W) ?
                               $clog2(NUM_CELLS) : tcas_pkg::IDX_W;

  tcas_pkg::cell_t state_q, state_d, cur;
  tcas_pkg::move_t own;
  logic [tcas_pkg::SPD_W-1:0] gap, vnew;
  logic [PW-1:0] pos_old, pos_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (tick_i) begin
      state_q <= state_d;
    end
  end

  assign cur     = inj_en_i ? inj_i : state_q;
  // stored contents, before any injection
  assign state_o = state_q;

  // gap: min(top speed, distance to first blocked cell ahead), at least 1
  always_comb begin
    gap = (cur.top == '0) ? tcas_pkg::SPD_W'(1) : cur.top;
    for (int k = tcas_pkg::SPD_MAX; k >= 1; k--) begin
      if (ahead_i[k-1] && (tcas_pkg::SPD_W'(k) < gap)) begin
        gap = tcas_pkg::SPD_W'(k);
      end
    end
  end

  always_comb begin
    vnew = cur.spd;
    if (gap > cur.spd) begin
      if (cur.spd < cur.top) begin
        vnew = cur.spd + tcas_pkg::SPD_W'(1);
      end
    end else if (gap < cur.spd) begin
      vnew = gap;
    end
  end

  assign pos_old = PW'(INDEX) + PW'(cur.spd);
  assign pos_new = PW'(INDEX) + PW'(vnew);
  assign exit_o  = cur.occ && ((pos_old >= PW'(NUM_CELLS)) || (pos_new >= PW'(NUM_CELLS)));

  assign own.vld = cur.occ && !exit_o;
  assign own.spd = vnew;
  assign own.top = cur.top;
  assign move_o  = own;

  // nearest source wins a landing conflict, so scan far to near
  always_comb begin
    state_d = '0;
    for (int s = tcas_pkg::SPD_MAX; s >= 1; s--) begin
      if (arrive_i[s-1].vld && (arrive_i[s-1].spd == tcas_pkg::SPD_W'(s))) begin
        state_d.occ = 1'b1;
        state_d.spd = arrive_i[s-1].spd;
        state_d.top = arrive_i[s-1].top;
      end
    end
    if (own.vld && (own.spd == '0)) begin
      state_d.occ = 1'b1;
      state_d.spd = own.spd;
      state_d.top = own.top;
    end
  end

  assign rd_o = (CW'(rd_idx_i) == CW'(INDEX)) ? state_q : '0;

endmodule

`default_nettype wire
